### rtl/core/b64d_pkg.sv
// Shared types, constants and the character lookup for the base64 stream decoder.
// No dependencies; every other file in rtl/core refers to it by scoped name.
package b64d_pkg;

	// Status codes carried on the closing item of a text
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
	localparam logic [1:0] STATUS_LONE     = 2'd2;

	// Alphabet selection
	localparam logic MODE_STANDARD = 1'b0;
	localparam logic MODE_URL_SAFE = 1'b1;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Command queue between front and back
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	typedef struct packed {
		logic [7:0] text_char;
		logic       text_end;
	} char_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic [1:0] status;
		logic       frame_done;
	} result_t;

	// One decoded request: up to three bytes, first byte in the top bits,
	// optionally followed by the closing status item.
	typedef struct packed {
		logic [23:0] bytes;
		logic [1:0]  nbytes;
		logic        with_status;
		logic [1:0]  status;
	} cmd_t;

	// Map a character to {in_alphabet, six-bit value}
	function automatic logic [6:0] sextet_of(input logic [7:0] c, input logic url);
		logic [7:0] d;
		logic [6:0] r;
		d = 8'd0;
		r = 7'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
			r = {1'b1, d[5:0]};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h61 + 8'd26;
			r = {1'b1, d[5:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d = c + 8'd4;
			r = {1'b1, d[5:0]};
		end else if (url == MODE_URL_SAFE) begin
			if (c == 8'h2D) r = {1'b1, 6'd62};
			else if (c == 8'h5F) r = {1'b1, 6'd63};
		end else begin
			if (c == 8'h2B) r = {1'b1, 6'd62};
			else if (c == 8'h2F) r = {1'b1, 6'd63};
		end
		return r;
	endfunction

endpackage

### rtl/core/b64d_front.sv
// Front end: accepts characters, decodes them and keeps the per-text group state.
// Depends on b64d_pkg; pushes requests into b64d_cmdq.
module b64d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              push,
	input  b64d_pkg::char_t   char_item,
	output logic              full,
	input  logic              q_full,
	output logic              cmd_push,
	output b64d_pkg::cmd_t    cmd
);

	logic        mode_q;
	logic [17:0] group_q;
	logic [1:0]  held_q;
	logic        pad_q;
	logic [1:0]  err_q;

	logic        accept;
	logic [6:0]  sx;
	logic [17:0] group_n;
	logic [1:0]  held_n;
	logic        pad_n;
	logic [1:0]  err_n;
	logic [23:0] bytes_n;
	logic [1:0]  nbytes_n;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign sx     = b64d_pkg::sextet_of(char_item.text_char, mode_q);

	// Decode one character and work out the bytes it releases
	always_comb begin
		group_n  = group_q;
		held_n   = held_q;
		pad_n    = pad_q;
		err_n    = err_q;
		bytes_n  = 24'd0;
		nbytes_n = 2'd0;
		if (err_q == b64d_pkg::STATUS_OK) begin
			if (mode_q == b64d_pkg::MODE_STANDARD && char_item.text_char == b64d_pkg::PAD_CHAR) begin
				pad_n = 1'b1;
			end else if (pad_q) begin
				err_n = b64d_pkg::STATUS_BAD_CHAR;
			end else if (!sx[6]) begin
				err_n = b64d_pkg::STATUS_BAD_CHAR;
			end else if (held_q == 2'd3) begin
				bytes_n  = {group_q, sx[5:0]};
				nbytes_n = 2'd3;
				group_n  = 18'd0;
				held_n   = 2'd0;
			end else begin
				group_n = {group_q[11:0], sx[5:0]};
				held_n  = held_q + 2'd1;
			end
		end
		// Close the text: flush a short tail or flag a lone value
		if (char_item.text_end && err_n == b64d_pkg::STATUS_OK) begin
			case (held_n)
				2'd1: err_n = b64d_pkg::STATUS_LONE;
				2'd2: begin
					bytes_n  = {group_n[11:4], 16'd0};
					nbytes_n = 2'd1;
				end
				2'd3: begin
					bytes_n  = {group_n[17:10], group_n[9:2], 8'd0};
					nbytes_n = 2'd2;
				end
				default: ;
			endcase
		end
	end

	assign cmd_push        = accept && (nbytes_n != 2'd0 || char_item.text_end);
	assign cmd.bytes       = bytes_n;
	assign cmd.nbytes      = nbytes_n;
	assign cmd.with_status = char_item.text_end;
	assign cmd.status      = err_n;

	// Hold mode; advance group state on each accepted character, clear it at text end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= b64d_pkg::MODE_STANDARD;
			group_q <= 18'd0;
			held_q  <= 2'd0;
			pad_q   <= 1'b0;
			err_q   <= b64d_pkg::STATUS_OK;
		end else begin
			if (cfg_we) mode_q <= cfg_wdata;
			if (accept) begin
				if (char_item.text_end) begin
					group_q <= 18'd0;
					held_q  <= 2'd0;
					pad_q   <= 1'b0;
					err_q   <= b64d_pkg::STATUS_OK;
				end else begin
					group_q <= group_n;
					held_q  <= held_n;
					pad_q   <= pad_n;
					err_q   <= err_n;
				end
			end
		end
	end

endmodule

### rtl/core/b64d_cmdq.sv
// Short request queue that decouples the decode front from the output back end.
// Depends on b64d_pkg for the request type and depth.
module b64d_cmdq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  b64d_pkg::cmd_t  wr_cmd,
	output logic            q_full,
	input  logic            rd_en,
	output logic            head_valid,
	output b64d_pkg::cmd_t  head
);

	b64d_pkg::cmd_t                slot_q [b64d_pkg::CMDQ_DEPTH];
	logic [b64d_pkg::CMDQ_AW-1:0]  wr_ptr_q;
	logic [b64d_pkg::CMDQ_AW-1:0]  rd_ptr_q;
	logic [b64d_pkg::CMDQ_AW:0]    count_q;

	assign q_full     = count_q == (b64d_pkg::CMDQ_AW+1)'(b64d_pkg::CMDQ_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];

	// Store requests
	always_ff @(posedge clk) begin
		if (wr_en) slot_q[wr_ptr_q] <= wr_cmd;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

### rtl/core/b64d_back.sv
// Back end: splits each request into result items and holds them in an output register.
// Depends on b64d_pkg; reads requests from b64d_cmdq.
module b64d_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  b64d_pkg::cmd_t   head,
	output logic             rd_en,
	output logic             empty,
	input  logic             pop,
	output b64d_pkg::result_t result
);

	logic [1:0]          k_q;
	logic                out_valid_q;
	b64d_pkg::result_t   out_q;

	logic                load;
	logic                last_item;
	logic                is_byte;
	logic [7:0]          sel_byte;
	b64d_pkg::result_t   item;

	assign load      = head_valid && (!out_valid_q || pop);
	assign last_item = head.with_status ? (k_q == head.nbytes) : (k_q == head.nbytes - 2'd1);
	assign is_byte   = k_q < head.nbytes;
	assign rd_en     = load && last_item;

	// Pick the byte for the current slot of the request
	always_comb begin
		case (k_q)
			2'd0:    sel_byte = head.bytes[23:16];
			2'd1:    sel_byte = head.bytes[15:8];
			default: sel_byte = head.bytes[7:0];
		endcase
		if (is_byte) begin
			item.data_byte  = sel_byte;
			item.byte_valid = 1'b1;
			item.status     = b64d_pkg::STATUS_OK;
			item.frame_done = 1'b0;
		end else begin
			item.data_byte  = 8'd0;
			item.byte_valid = 1'b0;
			item.status     = head.status;
			item.frame_done = 1'b1;
		end
	end

	// Hold payload until popped
	always_ff @(posedge clk) begin
		if (load) out_q <= item;
	end

	// Advance the slot counter and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) k_q <= last_item ? 2'd0 : k_q + 2'd1;
			if (load) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

### rtl/core/base64_stream_decoder.sv
// Top level of the base64 stream decoder: front decode, request queue, back end.
// Depends on b64d_pkg, b64d_front, b64d_cmdq and b64d_back.
//
//   channel   handshake       payload               accepted when
//   chars     push / full     char_item (char_t)    push && !full
//   results   empty / pop     result (result_t)     pop && !empty
//   config    cfg_we          cfg_wdata (mode)      cfg_we
//
// A character is taken every cycle while the four-entry request queue has room.
// Results leave one per cycle while they are popped; the output register is the
// only limit there, so a character that yields three or four results holds its
// queue entry until the last of them is loaded into the output register.
// Reset clears the mode to the standard alphabet, the group state and both queues.
module base64_stream_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              push,
	input  b64d_pkg::char_t   char_item,
	output logic              full,
	output logic              empty,
	input  logic              pop,
	output b64d_pkg::result_t result
);

	logic            q_full;
	logic            cmd_push;
	b64d_pkg::cmd_t  cmd;
	logic            rd_en;
	logic            head_valid;
	b64d_pkg::cmd_t  head;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.char_item (char_item),
		.full      (full),
		.q_full    (q_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd)
	);

	b64d_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cmd_push),
		.wr_cmd     (cmd),
		.q_full     (q_full),
		.rd_en      (rd_en),
		.head_valid (head_valid),
		.head       (head)
	);

	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.rd_en      (rd_en),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

### rtl/core/b64d_checker.sv
// Port-level checks for base64_stream_decoder, attached by bind.
// Depends on b64d_pkg and the top level's port list.
module b64d_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input b64d_pkg::char_t   char_item,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input b64d_pkg::result_t result
);

	// A waiting result stays put until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while waiting");

	// The closing character of a text must be followed by a waiting result
	a_end_out: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && char_item.text_end |=> ##1 !empty)
		else $error("no result after text end");

	// Leaving reset, both sides start clear
	a_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> empty && !full)
		else $error("queues not clear after reset");

	// A status item carries no byte
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.frame_done |-> !result.byte_valid && result.data_byte == 8'd0)
		else $error("status item carries byte data");

	// A data item carries no status
	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.frame_done |-> result.byte_valid
			&& result.status == b64d_pkg::STATUS_OK)
		else $error("data item malformed");

endmodule

bind base64_stream_decoder b64d_checker u_chk (.*);
